// ===== rtl/core/tccw_pkg.sv =====
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_IW  = $clog2(COLUMNS);
    localparam int ROW_IW  = $clog2(ROWS);

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int WORD_W    = 16;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int ATTR_W    = 8;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ATTR     = 1'd1;
    localparam logic [ATTR_W-1:0]    ATTR_RESET        = 8'd7;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam int                PROMPT_GUARD = 2;

    // Request actions
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Command kinds handed from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_NOP       = 3'd0;
    localparam logic [KIND_W-1:0] K_READ      = 3'd1;
    localparam logic [KIND_W-1:0] K_NEWLINE   = 3'd2;
    localparam logic [KIND_W-1:0] K_BACKSPACE = 3'd3;
    localparam logic [KIND_W-1:0] K_PRINT     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_cmd;

endpackage

// ===== rtl/core/tccw_front.sv =====
module tccw_front (
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tccw_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output tccw_pkg::t_cmd                o_q_cmd
);
    import tccw_pkg::*;

    logic [CHAR_W-1:0] w_char;

    assign w_char     = i_s_tdata[CHAR_W-1:0];
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

    // Sort the request into what the back end has to do
    always_comb begin
        o_q_cmd.char_code  = w_char;
        o_q_cmd.cell_index = i_s_tdata[CHAR_W+IDX_W-1:CHAR_W];
        if (i_s_tuser == ACT_READ) begin
            o_q_cmd.kind = K_READ;
        end else begin
            unique case (w_char)
                CH_NUL:       o_q_cmd.kind = K_NOP;
                CH_NEWLINE:   o_q_cmd.kind = K_NEWLINE;
                CH_BACKSPACE: o_q_cmd.kind = K_BACKSPACE;
                default:      o_q_cmd.kind = K_PRINT;
            endcase
        end
    end

endmodule

// ===== rtl/core/tccw_queue.sv =====
module tccw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tccw_pkg::t_cmd o_cmd
);
    import tccw_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/tccw_back.sv =====
module tccw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_terminal_mode,
    input  logic [tccw_pkg::ATTR_W-1:0]   i_cell_attr,
    input  logic                          i_q_valid,
    input  tccw_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tccw_pkg::M_DATA_W-1:0] o_m_tdata
);
    import tccw_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_RDWAIT = 2'd2;
    localparam int         PAD_W     = M_DATA_W - WORD_W - COL_W - ROW_W - 1;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [COL_IW-1:0] r_col, n_col;
    logic [ROW_IW-1:0] r_row, n_row;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_rd_oob, n_rd_oob;

    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_out_wiped;

    logic [CHAR_W-1:0] r_chars [CELLS];
    logic [CHAR_W-1:0] r_rdata;

    logic              w_out_free;
    logic              w_load;
    logic [WORD_W-1:0] w_word;
    logic              w_wiped;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_in_range;
    logic [COL_IW:0]   w_col_inc;
    logic [ROW_IW:0]   w_row_inc;
    logic [COL_IW:0]   w_limit;
    logic [31:0]       w_idx32;
    logic [31:0]       w_col32;
    logic [31:0]       w_row32;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_q_pop    = (r_state == ST_RUN) && i_q_valid && w_out_free;
    assign w_col_inc  = {1'b0, r_col} + 1'b1;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_limit    = i_terminal_mode ? (COL_IW + 1)'(PROMPT_GUARD) : '0;
    assign w_idx32    = 32'(i_q_cmd.cell_index);
    assign w_in_range = (w_idx32 < 32'(CELLS));
    assign w_raddr    = w_in_range ? w_idx32[ADDR_W-1:0] : '0;

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_col    = r_col;
        n_row    = r_row;
        n_addr   = r_addr;
        n_rd_oob = r_rd_oob;
        w_load   = 1'b0;
        w_word   = '0;
        w_wiped  = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_addr;
        w_wdata  = CH_SPACE;

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RDWAIT: begin
                w_load  = 1'b1;
                w_word  = r_rd_oob ? '0 : {i_cell_attr, r_rdata};
                n_state = ST_RUN;
            end
            default: begin
                if (o_q_pop) begin
                    w_load = (i_q_cmd.kind != K_READ);
                    unique case (i_q_cmd.kind)
                        K_READ: begin
                            n_rd_oob = !w_in_range;
                            n_state  = ST_RDWAIT;
                        end
                        K_NEWLINE: begin
                            n_col = '0;
                            if (w_row_inc == (ROW_IW + 1)'(ROWS)) begin
                                w_wiped = 1'b1;
                            end else begin
                                n_row  = w_row_inc[ROW_IW-1:0];
                                n_addr = r_addr - ADDR_W'(r_col) + ADDR_W'(COLUMNS);
                            end
                        end
                        K_BACKSPACE: begin
                            if ({1'b0, r_col} > w_limit) begin
                                n_col   = r_col - 1'b1;
                                n_addr  = r_addr - 1'b1;
                                w_we    = 1'b1;
                                w_waddr = r_addr - 1'b1;
                            end
                        end
                        K_PRINT: begin
                            w_we    = 1'b1;
                            w_wdata = i_q_cmd.char_code;
                            n_addr  = r_addr + 1'b1;
                            if (w_col_inc == (COL_IW + 1)'(COLUMNS)) begin
                                n_col = '0;
                                if (w_row_inc == (ROW_IW + 1)'(ROWS)) begin
                                    w_wiped = 1'b1;
                                end else begin
                                    n_row = w_row_inc[ROW_IW-1:0];
                                end
                            end else begin
                                n_col = w_col_inc[COL_IW-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                    // Ran past the last row: home and sweep the store
                    if (w_wiped) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_addr  = '0;
                        n_sweep = '0;
                        n_state = ST_CLEAR;
                    end
                end
            end
        endcase
    end

    assign n_out_valid = w_load || (r_out_valid && !i_m_tready);
    assign w_col32     = 32'(n_col);
    assign w_row32     = 32'(n_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            r_rd_oob    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_col       <= n_col;
            r_row       <= n_row;
            r_addr      <= n_addr;
            r_rd_oob    <= n_rd_oob;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word  <= w_word;
            r_out_col   <= w_col32[COL_W-1:0];
            r_out_row   <= w_row32[ROW_W-1:0];
            r_out_wiped <= w_wiped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_chars[w_waddr] <= w_wdata;
        end
        r_rdata <= r_chars[w_raddr];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {PAD_W'(0), r_out_wiped, r_out_row, r_out_col, r_out_word};

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < 32'(ROWS))
        else $error("cursor row out of range");

    a_addr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_addr) == 32'(r_row) * 32'(COLUMNS) + 32'(r_col))
        else $error("linear cursor address lost track of row and column");

    a_wipe_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_wiped |=> r_state == ST_CLEAR && r_col == '0 && r_row == '0)
        else $error("screen wipe did not home cursor and start sweep");
`endif

endmodule

// ===== rtl/core/text_console_char_writer.sv =====
// Text console character writer: an 80x25 store of character bytes with a write
// cursor. Each request on the s-side is either a put (tuser 0) of one byte, where
// newline goes to the next row, backspace steps left and blanks a cell (never
// into the two prompt columns while terminal mode is set), byte 0 is dropped and
// any other byte is stored and advances the cursor, or a read (tuser 1) of one
// cell for scanout. Every request gives exactly one m-side result carrying the
// cell word (attribute high byte, character low byte; zero for puts and for
// indexes past the screen) and the cursor after the request. A front stage sorts
// requests into a two-entry queue, so intake goes on while the back end works or
// the m-side stalls. The back end carries out a put in its run state and a read
// in the run state and then the read-wait state (registered read of the character
// memory). After reset, and after any put that runs past the last row, the back
// end sweeps all 2000 cells to space, one per cycle; during the sweep no request
// is carried out and intake stops once the queue is full. Configuration writes may
// be made at any time the block is idle.
module text_console_char_writer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tccw_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [tccw_pkg::S_DATA_W-1:0]  i_s_tdata,  // char_code[7:0], cell_index[18:8]
    input  logic                           i_s_tuser,  // action
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tccw_pkg::M_DATA_W-1:0]  o_m_tdata   // cell_word[15:0], col_now[22:16],
                                                       // row_now[27:23], screen_wiped[28]
);
    import tccw_pkg::*;

    logic              r_terminal_mode;
    logic [ATTR_W-1:0] r_cell_attr;

    logic              w_q_push;
    t_cmd              w_q_in;
    logic              w_q_full;
    logic              w_q_pop;
    logic              w_q_valid;
    t_cmd              w_q_out;

    // Configuration registers; writes must land only while idle, left to the user
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terminal_mode <= 1'b0;
            r_cell_attr     <= ATTR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TERMINAL_MODE: r_terminal_mode <= i_cfg_wdata[0];
                CFG_CELL_ATTR:     r_cell_attr     <= i_cfg_wdata[ATTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept and sort requests
    tccw_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_cmd    (w_q_in)
    );

    // Queue: decouple intake from execution
    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_out)
    );

    // Back: cursor, character memory, clear sweep and result register
    tccw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_terminal_mode (r_terminal_mode),
        .i_cell_attr     (r_cell_attr),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_out),
        .o_q_pop         (w_q_pop),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_m_tdata       (o_m_tdata)
    );

endmodule
